>>> sv/tilt_measurement_model_top_assert.svh
// assertion macros shared by the tilt measurement block
`ifndef TILT_MEASUREMENT_MODEL_TOP_ASSERT_SVH
`define TILT_MEASUREMENT_MODEL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define TMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tilt measurement check failed");
// next-cycle implication, checked out of reset
`define TMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tilt measurement check failed");
`else
`define TMM_ASSERT_NOW(lbl, ante, cons)
`define TMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/tmm_pkg.sv
`default_nettype none
package tmm_pkg;

    localparam int ANGLE_W            = 16;
    localparam int Q_W                = 32;
    localparam int G_W                = 15;
    localparam int TURN_W             = 30;
    localparam int CORDIC_STEPS       = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;
    localparam int REG_IDX_BIT        = 2;

    // register indexes
    localparam logic [0:0] REG_GRAVITY = 1'b0;

    localparam logic [G_W-1:0]    G_RESET      = 15'd15691;
    localparam logic [TURN_W-1:0] TURN_PER_RAD = 30'd683565276;
    localparam logic signed [Q_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [Q_W-1:0] QUARTER_TURN = 32'sd1073741824;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic signed [Q_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667330,  32'sd21354465,  32'sd10679839,  32'sd5340247,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
        logic                  neg;
    } t_cordic;

    typedef struct packed {
        logic                      req_type;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
    } t_side;

    localparam logic REQ_ACCEL = 1'b0;
    localparam logic REQ_KIN   = 1'b1;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7fff;
        end else if (v < -19'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/tmm_phase.sv
`default_nettype none
module tmm_phase #(
    parameter int ANGLE_FRAC_BITS = tmm_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [tmm_pkg::ANGLE_W-1:0]    i_angle,
    output tmm_pkg::t_cordic                           o_state
);
    import tmm_pkg::*;

    localparam int PROD_W = ANGLE_W + TURN_W + 1;
    localparam int EXT_W  = ANGLE_FRAC_BITS + Q_W;

    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [EXT_W-1:0]  prod_ext;
    logic signed [Q_W-1:0]    phase;
    t_cordic                  r_state, n_state;

    // angle to turn fraction
    assign n_prod = PROD_W'(i_angle) * PROD_W'($signed({1'b0, TURN_PER_RAD}));

    // floor shift then keep one turn
    assign prod_ext = EXT_W'(r_prod);
    assign phase    = prod_ext[ANGLE_FRAC_BITS +: Q_W];

    // fold past a quarter turn: move half a turn, flip the result sign
    always_comb begin
        n_state.x   = CORDIC_GAIN;
        n_state.y   = '0;
        n_state.z   = phase;
        n_state.neg = 1'b0;
        if (phase > QUARTER_TURN || phase < -QUARTER_TURN) begin
            n_state.z   = {~phase[Q_W-1], phase[Q_W-2:0]};
            n_state.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

>>> sv/tmm_cordic_step.sv
`default_nettype none
module tmm_cordic_step #(
    parameter int STEP = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire tmm_pkg::t_cordic   i_state,
    output tmm_pkg::t_cordic        o_state
);
    import tmm_pkg::*;

    logic signed [Q_W-1:0] dx, dy;
    t_cordic               r_state, n_state;

    assign dx = $signed(i_state.y) >>> STEP;
    assign dy = $signed(i_state.x) >>> STEP;

    always_comb begin
        n_state.neg = i_state.neg;
        if (!i_state.z[Q_W-1]) begin
            n_state.x = i_state.x - dx;
            n_state.y = i_state.y + dy;
            n_state.z = i_state.z - STEP_ANGLE[STEP];
        end else begin
            n_state.x = i_state.x + dx;
            n_state.y = i_state.y - dy;
            n_state.z = i_state.z + STEP_ANGLE[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

>>> sv/tmm_scale.sv
`default_nettype none
module tmm_scale (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic [tmm_pkg::G_W-1:0]            i_gravity,
    input  wire tmm_pkg::t_cordic                   i_roll,
    input  wire tmm_pkg::t_cordic                   i_pitch,
    input  wire tmm_pkg::t_side                     i_side,
    output logic signed [tmm_pkg::ANGLE_W-1:0]      o_comp_x,
    output logic signed [tmm_pkg::ANGLE_W-1:0]      o_comp_y,
    output logic signed [tmm_pkg::ANGLE_W-1:0]      o_comp_z
);
    import tmm_pkg::*;

    localparam int PP_W = 2 * Q_W;
    localparam int GP_W = G_W + 1 + Q_W + 1;
    localparam int W_W  = GP_W - 30;
    localparam logic signed [PP_W-1:0] RND_PP = PP_W'(64'sd536870912);
    localparam logic signed [GP_W-1:0] RND_GP = GP_W'(64'sd536870912);

    logic signed [G_W:0]    g_s;
    logic signed [Q_W-1:0]  sr, cr, sp, cp;

    // stage a: trig products and g*sin(pitch)
    logic signed [PP_W-1:0] r_prod_y, r_prod_z;
    logic signed [GP_W-1:0] r_prod_gx;
    // stage b: rounded terms
    logic signed [Q_W-1:0]  r_ty, r_tz;
    logic signed [W_W-1:0]  r_gx_b;
    // stage c: gravity products
    logic signed [GP_W-1:0] r_prod_gy, r_prod_gz;
    logic signed [W_W-1:0]  r_gx_c;
    // stage d: outputs
    logic signed [ANGLE_W-1:0] r_comp_x, r_comp_y, r_comp_z;

    logic signed [PP_W-1:0] sum_y, sum_z;
    logic signed [GP_W-1:0] sum_gx, sum_gy, sum_gz;
    logic signed [W_W-1:0]  w_y, w_z;
    logic signed [W_W:0]    neg_y, neg_z;
    logic signed [ANGLE_W-1:0] n_comp_x, n_comp_y, n_comp_z;

    assign g_s = $signed({1'b0, i_gravity});

    // undo the quadrant fold
    assign sr = i_roll.neg  ? -i_roll.y  : i_roll.y;
    assign cr = i_roll.neg  ? -i_roll.x  : i_roll.x;
    assign sp = i_pitch.neg ? -i_pitch.y : i_pitch.y;
    assign cp = i_pitch.neg ? -i_pitch.x : i_pitch.x;

    assign sum_y  = r_prod_y + RND_PP;
    assign sum_z  = r_prod_z + RND_PP;
    assign sum_gx = r_prod_gx + RND_GP;
    assign sum_gy = r_prod_gy + RND_GP;
    assign sum_gz = r_prod_gz + RND_GP;
    assign w_y    = sum_gy[GP_W-1:30];
    assign w_z    = sum_gz[GP_W-1:30];
    assign neg_y  = -((W_W+1)'(w_y));
    assign neg_z  = -((W_W+1)'(w_z));

    always_comb begin
        if (i_side.req_type == REQ_KIN) begin
            n_comp_x = i_side.roll_angle;
            n_comp_y = i_side.pitch_angle;
            n_comp_z = '0;
        end else begin
            n_comp_x = sat16(19'(r_gx_c));
            n_comp_y = sat16(19'(neg_y));
            n_comp_z = sat16(19'(neg_z));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_y  <= PP_W'(sr) * PP_W'(cp);
            r_prod_z  <= PP_W'(cr) * PP_W'(cp);
            r_prod_gx <= GP_W'(g_s) * GP_W'(sp);
            r_ty      <= sum_y[Q_W+29:30];
            r_tz      <= sum_z[Q_W+29:30];
            r_gx_b    <= sum_gx[GP_W-1:30];
            r_prod_gy <= GP_W'(g_s) * GP_W'(r_ty);
            r_prod_gz <= GP_W'(g_s) * GP_W'(r_tz);
            r_gx_c    <= r_gx_b;
            r_comp_x  <= n_comp_x;
            r_comp_y  <= n_comp_y;
            r_comp_z  <= n_comp_z;
        end
    end

    assign o_comp_x = r_comp_x;
    assign o_comp_y = r_comp_y;
    assign o_comp_z = r_comp_z;

endmodule
`default_nettype wire

>>> sv/tilt_measurement_model_top.sv
`default_nettype none
// tilt measurement: for each input beat with req_type 0 the block returns the gravity
// reading an accelerometer would see at the given roll and pitch, x = g*sin(pitch),
// y = -g*sin(roll)*cos(pitch), z = -g*cos(roll)*cos(pitch), each saturated to 16 bits,
// with g taken from the gravity_magnitude register (1/16 cm/s^2, offset 0x0);
// with req_type 1 it returns roll and pitch unchanged and z = 0. one beat is taken
// per clock while not stalled, and every beat gives exactly one result beat after it
// passes the angle to phase multiply and quadrant fold, the pipelined cordic (one
// rotation per stage, roll and pitch side by side), then the products, gravity
// scaling and output register. when the output beat is stalled the whole pipeline
// holds, so input stall follows output stall in the same cycle.
// the gravity register should only be written while no beat is in flight.
`include "tilt_measurement_model_top_assert.svh"
module tilt_measurement_model_top #(
    parameter int ANGLE_FRAC_BITS = tmm_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input beat
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_req_type,
    input  wire logic signed [tmm_pkg::ANGLE_W-1:0]    i_roll_angle,
    input  wire logic signed [tmm_pkg::ANGLE_W-1:0]    i_pitch_angle,
    // result beat
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [tmm_pkg::ANGLE_W-1:0]         o_comp_x,
    output logic signed [tmm_pkg::ANGLE_W-1:0]         o_comp_y,
    output logic signed [tmm_pkg::ANGLE_W-1:0]         o_comp_z,
    // register port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tmm_pkg::PADDR_W-1:0]           paddr,
    input  wire logic [tmm_pkg::PDATA_W-1:0]           pwdata,
    output logic [tmm_pkg::PDATA_W-1:0]                prdata,
    output logic                                       pready
);
    import tmm_pkg::*;

    // phase multiply, fold, cordic steps, four scaling stages
    localparam int NUM_STAGES = 2 + CORDIC_STEPS + 4;
    localparam int SIDE_LAST  = NUM_STAGES - 2;

    logic                   en;
    logic [NUM_STAGES-1:0]  r_vld;
    t_side                  r_side [SIDE_LAST+1];
    t_side                  in_side;
    logic [G_W-1:0]         r_gravity;
    logic                   cfg_wr;

    t_cordic roll_st  [CORDIC_STEPS+1];
    t_cordic pitch_st [CORDIC_STEPS+1];

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[REG_IDX_BIT] == REG_GRAVITY);
    assign prdata = (paddr[REG_IDX_BIT] == REG_GRAVITY) ? PDATA_W'(r_gravity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= G_RESET;
        end else if (cfg_wr) begin
            r_gravity <= pwdata[G_W-1:0];
        end
    end

    // ---------------- pipeline control ----------------
    // everything moves unless a finished result is held by the receiver
    assign en      = !(r_vld[NUM_STAGES-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
        end
    end

    // request kind and raw angles ride along for the kinematic bypass
    assign in_side.req_type    = i_req_type;
    assign in_side.roll_angle  = i_roll_angle;
    assign in_side.pitch_angle = i_pitch_angle;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= in_side;
            for (int k = 1; k <= SIDE_LAST; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- angle to phase ----------------
    tmm_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_roll_angle),
        .o_state (roll_st[0])
    );

    tmm_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_pitch_angle),
        .o_state (pitch_st[0])
    );

    // ---------------- cordic rotation, one step per stage ----------------
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        tmm_cordic_step #(.STEP(g)) u_step_roll (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_state (roll_st[g]),
            .o_state (roll_st[g+1])
        );
        tmm_cordic_step #(.STEP(g)) u_step_pitch (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_state (pitch_st[g]),
            .o_state (pitch_st[g+1])
        );
    end

    // ---------------- products, gravity scale, output register ----------------
    tmm_scale u_scale (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_gravity (r_gravity),
        .i_roll    (roll_st[CORDIC_STEPS]),
        .i_pitch   (pitch_st[CORDIC_STEPS]),
        .i_side    (r_side[SIDE_LAST]),
        .o_comp_x  (o_comp_x),
        .o_comp_y  (o_comp_y),
        .o_comp_z  (o_comp_z)
    );

    // ---------------- checks ----------------
    // a kinematic beat entering the output register comes out with z cleared
    `TMM_ASSERT_NEXT(a_kin_z_zero, en && r_vld[SIDE_LAST] && r_side[SIDE_LAST].req_type, o_valid && o_comp_z == 0)
    // a kinematic beat carries roll through to x
    `TMM_ASSERT_NEXT(a_kin_roll, en && r_vld[SIDE_LAST] && r_side[SIDE_LAST].req_type, o_comp_x == $past(r_side[SIDE_LAST].roll_angle))
    // a bubble advancing into the output register leaves no result
    `TMM_ASSERT_NEXT(a_bubble, en && !r_vld[SIDE_LAST], !o_valid)
    // the gravity register takes the written value
    `TMM_ASSERT_NEXT(a_cfg_write, cfg_wr, r_gravity == $past(pwdata[G_W-1:0]))
    // an input stall is only ever raised by a held result
    `TMM_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall)

endmodule
`default_nettype wire
